### src/aet_pkg.sv
// shared constants and types for the contact event tracker
package aet_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int ID_BITS_DEF     = 16;
  localparam int COORD_BITS_DEF  = 20;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } contact_ev_e;

  // flags of the search token that walks the cell row
  typedef struct packed {
    logic vld;
    logic found;
    logic have_free;
  } scan_flags_t;

  // table update broadcast to all cells
  typedef struct packed {
    logic set;
    logic clr;
  } table_wr_t;

endpackage

### src/aet_if.sv
// handshake channels for box pair words and contact result words
interface aet_in_if
  import aet_pkg::*;
#(
  parameter int IdBits    = ID_BITS_DEF,
  parameter int CoordBits = COORD_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic        [IdBits-1:0]    first_id;
  logic signed [CoordBits-1:0] first_x;
  logic signed [CoordBits-1:0] first_y;
  logic        [CoordBits-1:0] first_w;
  logic        [CoordBits-1:0] first_h;
  logic        [IdBits-1:0]    second_id;
  logic signed [CoordBits-1:0] second_x;
  logic signed [CoordBits-1:0] second_y;
  logic        [CoordBits-1:0] second_w;
  logic        [CoordBits-1:0] second_h;

  modport source (
    output valid, first_id, first_x, first_y, first_w, first_h,
           second_id, second_x, second_y, second_w, second_h,
    input  ready
  );
  modport sink (
    input  valid, first_id, first_x, first_y, first_w, first_h,
           second_id, second_x, second_y, second_w, second_h,
    output ready
  );
endinterface

interface aet_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] contact_event;
  logic       overlapping;
  logic       table_full;

  modport source (output valid, contact_event, overlapping, table_full, input ready);
  modport sink   (input  valid, contact_event, overlapping, table_full, output ready);
endinterface

### src/aet_cell.sv
// one table entry: stores a pair key and updates the passing search token
module aet_cell
  import aet_pkg::*;
#(
  parameter int KeyBits = 2 * ID_BITS_DEF,
  parameter int IdxBits = 6,
  parameter int Index   = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scan_flags_t        tok_flags_i,
  input  logic [KeyBits-1:0] tok_key_i,
  input  logic [IdxBits-1:0] tok_hit_i,
  input  logic [IdxBits-1:0] tok_free_i,
  output scan_flags_t        tok_flags_o,
  output logic [KeyBits-1:0] tok_key_o,
  output logic [IdxBits-1:0] tok_hit_o,
  output logic [IdxBits-1:0] tok_free_o,
  input  table_wr_t          wr_i,
  input  logic [IdxBits-1:0] wr_idx_i,
  input  logic [KeyBits-1:0] wr_key_i
);

  localparam logic [IdxBits-1:0] MyIdx = IdxBits'(Index);

  logic               entry_vld_q;
  logic [KeyBits-1:0] entry_key_q;
  scan_flags_t        flags_d;
  logic [IdxBits-1:0] hit_d;
  logic [IdxBits-1:0] free_d;
  logic               match;
  logic               sel;

  assign match = entry_vld_q && (entry_key_q == tok_key_i);
  assign sel   = (wr_idx_i == MyIdx);

  always_comb begin
    flags_d           = tok_flags_i;
    flags_d.found     = tok_flags_i.found | match;
    flags_d.have_free = tok_flags_i.have_free | !entry_vld_q;
    hit_d  = (!tok_flags_i.found && match) ? MyIdx : tok_hit_i;
    free_d = (!tok_flags_i.have_free && !entry_vld_q) ? MyIdx : tok_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_flags_o <= '0;
      entry_vld_q <= 1'b0;
    end else begin
      tok_flags_o <= flags_d;
      if (sel && wr_i.set) begin
        entry_vld_q <= 1'b1;
      end else if (sel && wr_i.clr) begin
        entry_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_key_o  <= tok_key_i;
    tok_hit_o  <= hit_d;
    tok_free_o <= free_d;
    if (sel && wr_i.set) begin
      entry_key_q <= wr_key_i;
    end
  end

endmodule

### src/aet_chain.sv
// row of table cells that the search token walks, one cell a cycle
module aet_chain
  import aet_pkg::*;
#(
  parameter int Depth   = TABLE_DEPTH_DEF,
  parameter int KeyBits = 2 * ID_BITS_DEF,
  parameter int IdxBits = $clog2(TABLE_DEPTH_DEF)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scan_flags_t        tok_flags_i,
  input  logic [KeyBits-1:0] tok_key_i,
  output scan_flags_t        tok_flags_o,
  output logic [IdxBits-1:0] tok_hit_o,
  output logic [IdxBits-1:0] tok_free_o,
  input  table_wr_t          wr_i,
  input  logic [IdxBits-1:0] wr_idx_i,
  input  logic [KeyBits-1:0] wr_key_i
);

  scan_flags_t        flags [Depth+1];
  logic [KeyBits-1:0] keys  [Depth+1];
  logic [IdxBits-1:0] hits  [Depth+1];
  logic [IdxBits-1:0] frees [Depth+1];

  assign flags[0] = tok_flags_i;
  assign keys[0]  = tok_key_i;
  assign hits[0]  = '0;
  assign frees[0] = '0;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    aet_cell #(
      .KeyBits (KeyBits),
      .IdxBits (IdxBits),
      .Index   (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_flags_i (flags[g]),
      .tok_key_i   (keys[g]),
      .tok_hit_i   (hits[g]),
      .tok_free_i  (frees[g]),
      .tok_flags_o (flags[g+1]),
      .tok_key_o   (keys[g+1]),
      .tok_hit_o   (hits[g+1]),
      .tok_free_o  (frees[g+1]),
      .wr_i        (wr_i),
      .wr_idx_i    (wr_idx_i),
      .wr_key_i    (wr_key_i)
    );
  end

  assign tok_flags_o = flags[Depth];
  assign tok_hit_o   = hits[Depth];
  assign tok_free_o  = frees[Depth];

endmodule

### src/aabb_contact_event_tracker.sv
// top level: box overlap test and enter/stay/exit tracking over a cell row
// steps: accept in idle, launch, token walk through the TABLE_DEPTH cells, then table
//   update and result; a new pair word is taken only after that update step, and a
//   waiting result does not block the next accept
// reset: asynchronous, clears all entry valid bits at once, table empty
module aabb_contact_event_tracker
  import aet_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  aet_in_if.sink   in_i,
  aet_out_if.source out_o
);

  localparam int KeyBits = 2 * ID_BITS;
  localparam int IdxBits = $clog2(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_ACT
  } state_e;

  state_e state_q;

  logic        [ID_BITS-1:0]    id_a_q, id_b_q;
  logic signed [COORD_BITS-1:0] xa_q, ya_q, xb_q, yb_q;
  logic        [COORD_BITS-1:0] wa_q, ha_q, wb_q, hb_q;

  logic               ov_q;
  logic               found_q, have_free_q;
  logic [IdxBits-1:0] hit_q, free_q;

  logic               out_valid_q, ov_out_q, full_q;
  contact_ev_e        ev_q;

  scan_flags_t        tok_in, tok_out;
  logic [IdxBits-1:0] tok_hit, tok_free;
  logic [KeyBits-1:0] key;
  table_wr_t          wr;
  logic [IdxBits-1:0] wr_idx;
  logic               ov_now, can_go;
  contact_ev_e        ev_d;
  logic               full_d;

  // axis test: 2*|c1 - c2| <= s1 + s2
  function automatic logic axis_ov(input logic signed [COORD_BITS-1:0] c1,
                                   input logic signed [COORD_BITS-1:0] c2,
                                   input logic [COORD_BITS-1:0] s1,
                                   input logic [COORD_BITS-1:0] s2);
    logic signed [COORD_BITS:0] d;
    logic        [COORD_BITS:0] ad;
    logic        [COORD_BITS:0] sum;
    d   = {c1[COORD_BITS-1], c1} - {c2[COORD_BITS-1], c2};
    ad  = d[COORD_BITS] ? (COORD_BITS+1)'(-d) : d;
    sum = {1'b0, s1} + {1'b0, s2};
    return {ad, 1'b0} <= {1'b0, sum};
  endfunction

  assign key = (id_a_q > id_b_q) ? {id_a_q, id_b_q} : {id_b_q, id_a_q};
  assign ov_now = axis_ov(xa_q, xb_q, wa_q, wb_q) && axis_ov(ya_q, yb_q, ha_q, hb_q);

  assign in_i.ready = (state_q == ST_IDLE);
  assign can_go = (state_q == ST_ACT) && (!out_valid_q || out_o.ready);

  always_comb begin
    tok_in           = '0;
    tok_in.vld       = (state_q == ST_LAUNCH);
  end

  always_comb begin
    ev_d   = EV_NONE;
    full_d = 1'b0;
    wr     = '0;
    wr_idx = free_q;
    if (found_q) begin
      wr_idx = hit_q;
      if (ov_q) begin
        ev_d = EV_STAY;
      end else begin
        ev_d   = EV_EXIT;
        wr.clr = can_go;
      end
    end else if (ov_q) begin
      ev_d = EV_ENTER;
      if (have_free_q) begin
        wr.set = can_go;
      end else begin
        full_d = 1'b1;
      end
    end
  end

  aet_chain #(
    .Depth   (TABLE_DEPTH),
    .KeyBits (KeyBits),
    .IdxBits (IdxBits)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_flags_i (tok_in),
    .tok_key_i   (key),
    .tok_flags_o (tok_out),
    .tok_hit_o   (tok_hit),
    .tok_free_o  (tok_free),
    .wr_i        (wr),
    .wr_idx_i    (wr_idx),
    .wr_key_i    (key)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // a new word replacing the one taken this cycle keeps valid high
      if (out_valid_q && out_o.ready && !can_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            state_q <= ST_LAUNCH;
          end
        end
        ST_LAUNCH: begin
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (tok_out.vld) begin
            state_q <= ST_ACT;
          end
        end
        ST_ACT: begin
          if (can_go) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      id_a_q <= in_i.first_id;
      xa_q   <= in_i.first_x;
      ya_q   <= in_i.first_y;
      wa_q   <= in_i.first_w;
      ha_q   <= in_i.first_h;
      id_b_q <= in_i.second_id;
      xb_q   <= in_i.second_x;
      yb_q   <= in_i.second_y;
      wb_q   <= in_i.second_w;
      hb_q   <= in_i.second_h;
    end
    if (state_q == ST_LAUNCH) begin
      ov_q <= ov_now;
    end
    if (state_q == ST_SCAN && tok_out.vld) begin
      found_q     <= tok_out.found;
      have_free_q <= tok_out.have_free;
      hit_q       <= tok_hit;
      free_q      <= tok_free;
    end
    if (can_go) begin
      ev_q     <= ev_d;
      ov_out_q <= ov_q;
      full_q   <= full_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.contact_event = ev_q;
  assign out_o.overlapping   = ov_out_q;
  assign out_o.table_full    = full_q;

  // table_full only comes with an enter
  a_full_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && full_q) |-> (ev_q == EV_ENTER))
    else $error("table_full without enter");

  // event and overlap flag agree
  a_ev_ov : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (ov_out_q == ((ev_q == EV_ENTER) || (ev_q == EV_STAY))))
    else $error("event does not match overlap");

  // the token leaves the row only while the search is pending
  a_tok_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_out.vld |-> (state_q == ST_SCAN))
    else $error("stray search token");

  // a new result word only follows the update step
  a_res_act : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_ACT))
    else $error("result without update step");

  // table is written only while a result is issued
  a_wr_act : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.set || wr.clr) |=> out_valid_q)
    else $error("table write without result");

endmodule

### tb/sv/aet_checker.sv
`timescale 1ns / 100ps
// contact tracker checker: watches both channels, predicts each result word and compares it
module aet_checker
  import aet_pkg::*;
#(
  parameter int TableDepth = TABLE_DEPTH_DEF,
  parameter int IdBits     = ID_BITS_DEF,
  parameter int CoordBits  = COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  aet_in_if    pair_i,
  aet_out_if   result_i,
  output int   err_cnt_o,
  output int   due_cnt_o,
  output int   result_cnt_o,
  output int   enter_cnt_o,
  output int   stay_cnt_o,
  output int   exit_cnt_o,
  output int   full_cnt_o
);

  typedef struct packed {
    contact_ev_e ev;
    logic        ov;
    logic        full;
  } contact_t;

  logic [2*IdBits-1:0] pair_key_q  [TableDepth];
  logic                pair_live_q [TableDepth];
  contact_t            due_contacts [$];

  // both boxes share this axis when 2*|center gap| <= sum of sizes
  function automatic logic axis_touch(logic signed [CoordBits-1:0] ca,
                                      logic signed [CoordBits-1:0] cb,
                                      logic [CoordBits-1:0] sa, logic [CoordBits-1:0] sb);
    longint span;
    span = longint'(ca) - longint'(cb);
    if (span < 0) span = -span;
    return (2 * span) <= (longint'(sa) + longint'(sb));
  endfunction

  function automatic contact_t track_contact(logic [IdBits-1:0] id_a, logic [IdBits-1:0] id_b,
                                             logic ov);
    logic [2*IdBits-1:0] key;
    int                  hit;
    int                  free_slot;
    contact_t            res;
    key = (id_a > id_b) ? {id_a, id_b} : {id_b, id_a};
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < TableDepth; i++) begin
      if (pair_live_q[i]) begin
        if (hit < 0 && pair_key_q[i] == key) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    res.ev = EV_NONE;
    res.ov = ov;
    res.full = 1'b0;
    if (hit >= 0) begin
      if (ov) begin
        res.ev = EV_STAY;
      end else begin
        res.ev = EV_EXIT;
        pair_live_q[hit] = 1'b0;
      end
    end else if (ov) begin
      res.ev = EV_ENTER;
      // no free entry: reported as enter but not remembered
      if (free_slot >= 0) begin
        pair_key_q[free_slot] = key;
        pair_live_q[free_slot] = 1'b1;
      end else begin
        res.full = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    contact_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TableDepth; i++) pair_live_q[i] = 1'b0;
      due_contacts.delete();
      err_cnt_o = 0;
      due_cnt_o = 0;
      result_cnt_o = 0;
      enter_cnt_o = 0;
      stay_cnt_o = 0;
      exit_cnt_o = 0;
      full_cnt_o = 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        result_cnt_o++;
        if (due_contacts.size() == 0) begin
          $error("result word with none expected: contact_event %0d overlapping %0d %s %0d",
                 result_i.contact_event, result_i.overlapping, "table_full",
                 result_i.table_full);
          err_cnt_o++;
        end else begin
          want = due_contacts.pop_front();
          if (result_i.contact_event !== want.ev) begin
            $error("contact_event: expected %0d, got %0d", want.ev, result_i.contact_event);
            err_cnt_o++;
          end
          if (result_i.overlapping !== want.ov) begin
            $error("overlapping: expected %0d, got %0d", want.ov, result_i.overlapping);
            err_cnt_o++;
          end
          if (result_i.table_full !== want.full) begin
            $error("table_full: expected %0d, got %0d", want.full, result_i.table_full);
            err_cnt_o++;
          end
          case (want.ev)
            EV_ENTER: enter_cnt_o++;
            EV_STAY:  stay_cnt_o++;
            EV_EXIT:  exit_cnt_o++;
            default:  ;
          endcase
          if (want.full) full_cnt_o++;
        end
      end
      if (pair_i.valid && pair_i.ready) begin
        due_contacts.insert(due_contacts.size(),
          track_contact(pair_i.first_id, pair_i.second_id,
            axis_touch(pair_i.first_x, pair_i.second_x, pair_i.first_w, pair_i.second_w) &&
            axis_touch(pair_i.first_y, pair_i.second_y, pair_i.first_h, pair_i.second_h)));
      end
      due_cnt_o = due_contacts.size();
    end
  end

endmodule

### tb/sv/aabb_contact_event_tracker_test.sv
`timescale 1ns / 100ps
// contact tracker testbench top: clock, reset, pair stimulus, result stalls and verdict
module aabb_contact_event_tracker_test
  import aet_pkg::*;
();

  localparam int IdMax      = 2**ID_BITS_DEF - 1;
  localparam int CoordMax   = 2**(COORD_BITS_DEF-1) - 1;
  localparam int CoordMin   = -(2**(COORD_BITS_DEF-1));
  localparam int SizeMax    = 2**COORD_BITS_DEF - 1;
  localparam int PoolSize   = 96;
  localparam int FillItems  = 80;
  localparam int ChurnItems = 250;
  localparam int NoiseItems = 120;
  localparam int HoldCycles = 1500;
  localparam int TailCycles = TABLE_DEPTH_DEF + 40;

  typedef struct packed {
    logic        [ID_BITS_DEF-1:0]    first_id;
    logic signed [COORD_BITS_DEF-1:0] first_x;
    logic signed [COORD_BITS_DEF-1:0] first_y;
    logic        [COORD_BITS_DEF-1:0] first_w;
    logic        [COORD_BITS_DEF-1:0] first_h;
    logic        [ID_BITS_DEF-1:0]    second_id;
    logic signed [COORD_BITS_DEF-1:0] second_x;
    logic signed [COORD_BITS_DEF-1:0] second_y;
    logic        [COORD_BITS_DEF-1:0] second_w;
    logic        [COORD_BITS_DEF-1:0] second_h;
  } box_pair_t;

  logic clk_i;
  logic rst_ni;
  int   err_cnt, due_cnt, result_cnt, enter_cnt, stay_cnt, exit_cnt, full_cnt;
  int   sent_cnt;
  int   burst_left;
  int   pool_a [PoolSize];
  int   pool_b [PoolSize];

  aet_in_if  pair_if ();
  aet_out_if result_if ();

  aabb_contact_event_tracker u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pair_if),
    .out_o  (result_if)
  );

  aet_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pair_i       (pair_if),
    .result_i     (result_if),
    .err_cnt_o    (err_cnt),
    .due_cnt_o    (due_cnt),
    .result_cnt_o (result_cnt),
    .enter_cnt_o  (enter_cnt),
    .stay_cnt_o   (stay_cnt),
    .exit_cnt_o   (exit_cnt),
    .full_cnt_o   (full_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("aabb_contact_event_tracker_test: done, errors");
    $finish;
  end

  function automatic box_pair_t box_pair(int ida, int xa, int ya, int wa, int ha,
                                         int idb, int xb, int yb, int wb, int hb);
    box_pair_t p;
    p.first_id  = ida[ID_BITS_DEF-1:0];
    p.first_x   = xa[COORD_BITS_DEF-1:0];
    p.first_y   = ya[COORD_BITS_DEF-1:0];
    p.first_w   = wa[COORD_BITS_DEF-1:0];
    p.first_h   = ha[COORD_BITS_DEF-1:0];
    p.second_id = idb[ID_BITS_DEF-1:0];
    p.second_x  = xb[COORD_BITS_DEF-1:0];
    p.second_y  = yb[COORD_BITS_DEF-1:0];
    p.second_w  = wb[COORD_BITS_DEF-1:0];
    p.second_h  = hb[COORD_BITS_DEF-1:0];
    return p;
  endfunction

  // geometry that overlaps or separates as asked, often right on the boundary
  function automatic box_pair_t shaped_pair(int id_a, int id_b, bit ov);
    int xa, ya, wa, ha, wb, hb, dx, dy, lim_x, lim_y, apart;
    xa = int'($urandom_range(400000)) - 200000;
    ya = int'($urandom_range(400000)) - 200000;
    wa = ($urandom_range(3) == 0) ? $urandom_range(16) : $urandom_range(100000);
    ha = ($urandom_range(3) == 0) ? $urandom_range(16) : $urandom_range(100000);
    wb = $urandom_range(100000);
    hb = $urandom_range(100000);
    lim_x = (wa + wb) / 2;
    lim_y = (ha + hb) / 2;
    dx = ($urandom_range(4) == 0) ? lim_x : $urandom_range(lim_x);
    dy = ($urandom_range(4) == 0) ? lim_y : $urandom_range(lim_y);
    if (!ov) begin
      apart = $urandom_range(2);
      if (apart != 1) dx = lim_x + 1 + (($urandom_range(3) == 0) ? 0 : $urandom_range(50000));
      if (apart != 0) dy = lim_y + 1 + (($urandom_range(3) == 0) ? 0 : $urandom_range(50000));
    end
    if ($urandom_range(1)) dx = -dx;
    if ($urandom_range(1)) dy = -dy;
    if ($urandom_range(1)) return box_pair(id_a, xa, ya, wa, ha, id_b, xa + dx, ya + dy, wb, hb);
    return box_pair(id_b, xa + dx, ya + dy, wb, hb, id_a, xa, ya, wa, ha);
  endfunction

  task automatic load_pair(box_pair_t p);
    pair_if.first_id  <= p.first_id;
    pair_if.first_x   <= p.first_x;
    pair_if.first_y   <= p.first_y;
    pair_if.first_w   <= p.first_w;
    pair_if.first_h   <= p.first_h;
    pair_if.second_id <= p.second_id;
    pair_if.second_x  <= p.second_x;
    pair_if.second_y  <= p.second_y;
    pair_if.second_w  <= p.second_w;
    pair_if.second_h  <= p.second_h;
  endtask

  // bursts of words with gaps between them, some gaps long enough to span a whole search
  task automatic offer_pair(box_pair_t p);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(2))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 6);
        default: gap = $urandom_range(1, 90);
      endcase
      if (gap > 0) begin
        pair_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(4) == 0) ? 40 : $urandom_range(1, 8);
    end
    burst_left--;
    pair_if.valid <= 1'b1;
    load_pair(p);
    do @(posedge clk_i); while (!pair_if.ready);
    sent_cnt++;
  endtask

  initial begin : pair_source
    box_pair_t noise;
    int        idx;
    sent_cnt = 0;
    burst_left = 0;
    rst_ni <= 1'b0;
    pair_if.valid <= 1'b0;
    load_pair('0);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero-size boxes, equal ids, full-range boundaries, one axis only
    offer_pair(box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer_pair(box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer_pair(box_pair(0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    offer_pair(box_pair(0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    offer_pair(box_pair(IdMax, CoordMin, 0, SizeMax, 0, 0, CoordMax, 0, SizeMax, 0));
    offer_pair(box_pair(0, CoordMax, 0, SizeMax, 0, IdMax, CoordMin, 0, SizeMax, 0));
    offer_pair(box_pair(IdMax, CoordMin, 0, SizeMax, 0, 0, CoordMax, 0, SizeMax - 1, 0));
    offer_pair(box_pair(IdMax, 0, CoordMax, 0, SizeMax, IdMax, 0, CoordMin, 0, SizeMax));
    offer_pair(box_pair(IdMax, 0, CoordMin, 0, SizeMax - 1, IdMax, 0, CoordMax, 0, SizeMax));
    offer_pair(box_pair('h5555, 0, 0, 100, 10, 'hAAAA, 10, 6, 100, 1));
    offer_pair(box_pair('hAAAA, 0, 0, 10, 100, 'h5555, 6, 10, 1, 100));
    offer_pair(box_pair('hAAAA, -16, -16, 32, 32, 'h5555, 16, 16, 32, 32));
    offer_pair(box_pair('h5555, 16, 16, 32, 32, 'hAAAA, -16, -16, 32, 32));
    offer_pair(box_pair('h1234, CoordMin, CoordMin, SizeMax, SizeMax,
                        'h1234, CoordMin, CoordMin, SizeMax, SizeMax));
    offer_pair(box_pair('h1234, CoordMax, CoordMax, 0, 0, 'h1234, CoordMin, CoordMin, 0, 0));

    for (int i = 0; i < PoolSize; i++) begin
      pool_a[i] = $urandom_range(IdMax);
      pool_b[i] = (i % 11 == 0) ? pool_a[i] : $urandom_range(IdMax);
    end
    // more overlapping pairs than table entries, so the last ones find it full
    for (int i = 0; i < FillItems; i++) offer_pair(shaped_pair(pool_a[i], pool_b[i], 1'b1));
    for (int i = 0; i < ChurnItems; i++) begin
      idx = $urandom_range(PoolSize - 1);
      offer_pair(shaped_pair(pool_a[idx], pool_b[idx], $urandom_range(99) < 55));
    end
    for (int i = 0; i < PoolSize; i++) offer_pair(shaped_pair(pool_a[i], pool_b[i], 1'b0));
    for (int i = 0; i < NoiseItems; i++) begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(7) == 0) noise.second_id = noise.first_id;
      offer_pair(noise);
    end

    pair_if.valid <= 1'b0;
    @(posedge clk_i);
    while (due_cnt != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    $display("sent %0d pair words, checked %0d results: %0d enter, %0d stay, %0d exit",
             sent_cnt, result_cnt, enter_cnt, stay_cnt, exit_cnt);
    $display("%0d overlaps hit a full table; result channel held off %0d cycles once",
             full_cnt, HoldCycles);
    if (err_cnt == 0) begin
      $display("aabb_contact_event_tracker_test: done, clean");
    end else begin
      $display("aabb_contact_event_tracker_test: done, errors");
    end
    $finish;
  end

  // result side: runs of always ready, coin-flip ready and mostly stalled, plus one long hold
  initial begin : result_sink
    int mode;
    int seg;
    bit held;
    held = 1'b0;
    result_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && result_cnt >= 120) begin
        held = 1'b1;
        result_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        mode = $urandom_range(2);
        seg = $urandom_range(10, 60);
        repeat (seg) begin
          case (mode)
            0:       result_if.ready <= 1'b1;
            1:       result_if.ready <= $urandom_range(1);
            default: result_if.ready <= ($urandom_range(7) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

endmodule
